@@ rtl/core/saq_pkg.sv @@
// Shared types and constants of the sorted alarm queue.
package saq_pkg;

   localparam int SAQ_DEPTH = 16;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_TICK   = 1'b1
   } op_type;

   typedef struct packed {
      op_type      opcode;
      logic [15:0] delay_seconds;
      logic [7:0]  alarm_id;
   } req_type;

   typedef struct packed {
      logic       fired;
      logic [7:0] fired_tag;
      logic       rejected;
      logic [4:0] pending;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXECUTE,
      ST_LOAD
   } state_type;

   typedef struct packed {
      logic capture;
      logic execute;
      logic load;
      logic respond;
   } cmd_type;

   typedef struct packed {
      logic can_load;
   } status_type;

endpackage

@@ rtl/core/saq_controller.sv @@
// Sequencer of the sorted alarm queue: accept, execute, load head, respond.
module saq_controller
   import saq_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      case (state_ff)
         ST_IDLE: begin
            state_in = start ? ST_EXECUTE : ST_IDLE;
         end
         ST_EXECUTE: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            busy        = 1'b0;
            cmd.capture = start;
         end
         ST_EXECUTE: begin
            cmd.execute = 1'b1;
         end
         ST_LOAD: begin
            cmd.load    = status.can_load;
            cmd.respond = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

endmodule

@@ rtl/core/saq_datapath.sv @@
// Datapath of the sorted alarm queue: sorted shift-register cells and countdown.
module saq_datapath
   import saq_pkg::*;
#(
   parameter int DEPTH = SAQ_DEPTH
)
(
   input  logic       clock,
   input  logic       reset,
   input  req_type    req_data,
   input  cmd_type    cmd,
   output status_type status,
   output logic       rsp_valid,
   output rsp_type    rsp_data
);

   localparam int CW = $clog2(DEPTH + 1);

   logic [15:0]   delay_ff [DEPTH];
   logic [15:0]   delay_in [DEPTH];
   logic [7:0]    tag_ff   [DEPTH];
   logic [7:0]    tag_in   [DEPTH];
   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;
   logic          counting_ff;
   logic          counting_in;
   logic [15:0]   remaining_ff;
   logic [15:0]   remaining_in;
   logic [7:0]    active_tag_ff;
   logic [7:0]    active_tag_in;
   req_type       req_ff;
   req_type       req_in;
   logic          fired_ff;
   logic          fired_in;
   logic [7:0]    fired_tag_ff;
   logic [7:0]    fired_tag_in;
   logic          rejected_ff;
   logic          rejected_in;
   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   rsp_type       rsp_data_ff;
   rsp_type       rsp_data_in;

   logic [DEPTH-1:0] le;
   logic             full;
   logic [CW+4:0]    count_ext;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         counting_ff   <= 1'b0;
         remaining_ff  <= '0;
         active_tag_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         count_ff      <= count_in;
         counting_ff   <= counting_in;
         remaining_ff  <= remaining_in;
         active_tag_ff <= active_tag_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      delay_ff     <= delay_in;
      tag_ff       <= tag_in;
      req_ff       <= req_in;
      fired_ff     <= fired_in;
      fired_tag_ff <= fired_tag_in;
      rejected_ff  <= rejected_in;
      rsp_data_ff  <= rsp_data_in;
   end

   always_comb begin
      for (int k = 0; k < DEPTH; k++) begin
         le[k] = (CW'(k) < count_ff) && (delay_ff[k] <= req_ff.delay_seconds);
      end
   end

   assign full            = (count_ff == CW'(DEPTH));
   assign status.can_load = !counting_ff && (count_ff != '0);

   always_comb begin
      delay_in      = delay_ff;
      tag_in        = tag_ff;
      count_in      = count_ff;
      counting_in   = counting_ff;
      remaining_in  = remaining_ff;
      active_tag_in = active_tag_ff;
      req_in        = cmd.capture ? req_data : req_ff;
      fired_in      = fired_ff;
      fired_tag_in  = fired_tag_ff;
      rejected_in   = rejected_ff;

      if (cmd.execute) begin
         fired_in     = 1'b0;
         fired_tag_in = '0;
         rejected_in  = 1'b0;
         if (req_ff.opcode == OP_INSERT) begin
            if (full) begin
               rejected_in = 1'b1;
            end else begin
               if (!le[0]) begin
                  delay_in[0] = req_ff.delay_seconds;
                  tag_in[0]   = req_ff.alarm_id;
               end
               for (int k = 1; k < DEPTH; k++) begin
                  if (!le[k]) begin
                     if (le[k-1]) begin
                        delay_in[k] = req_ff.delay_seconds;
                        tag_in[k]   = req_ff.alarm_id;
                     end else begin
                        delay_in[k] = delay_ff[k-1];
                        tag_in[k]   = tag_ff[k-1];
                     end
                  end
               end
               count_in = count_ff + CW'(1);
            end
         end else if (counting_ff) begin
            if (remaining_ff <= 16'd1) begin
               fired_in     = 1'b1;
               fired_tag_in = active_tag_ff;
               counting_in  = 1'b0;
               remaining_in = '0;
            end else begin
               remaining_in = remaining_ff - 16'd1;
            end
         end
      end

      if (cmd.load) begin
         remaining_in  = delay_ff[0];
         active_tag_in = tag_ff[0];
         counting_in   = 1'b1;
         for (int k = 0; k < DEPTH - 1; k++) begin
            delay_in[k] = delay_ff[k+1];
            tag_in[k]   = tag_ff[k+1];
         end
         count_in = count_ff - CW'(1);
      end
   end

   assign count_ext = {5'b0, count_in};

   always_comb begin
      rsp_valid_in          = cmd.respond;
      rsp_data_in.fired     = fired_ff;
      rsp_data_in.fired_tag = fired_tag_ff;
      rsp_data_in.rejected  = rejected_ff;
      rsp_data_in.pending   = count_ext[4:0];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ rtl/core/sorted_alarm_queue_core.sv @@
// Top level of the sorted alarm queue: controller and datapath.
//
// Each beat on req_data is an insert or a one-second tick. A beat is taken when start is
// high and busy is low; busy then stays high through the execute and head-load states (the
// response register fills during head load), so no new beat is taken before both are over.
// The result beat shows on rsp_data for exactly one cycle with rsp_valid high, registered
// from the head-load state, when busy is already low again, and the receiver cannot stall
// it. Inserts land in a row of DEPTH shift-register cells that compare against the new
// delay in parallel; equal delays queue behind older ones. An insert into a full queue is
// dropped and flagged as rejected. Pending counts wrap modulo 32.
module sorted_alarm_queue_core
   import saq_pkg::*;
#(
   parameter int DEPTH = SAQ_DEPTH
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   cmd_type    cmd;
   status_type status;

   saq_controller u_controller (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   saq_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

@@ test/sorted_alarm_queue_core_tb.sv @@
// Self-checking testbench for the sorted alarm queue: directed table, then random beats.
module sorted_alarm_queue_core_tb;
   import saq_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_BEATS = 1275;
   localparam int SHORT_REACH  = 40;
   localparam int FAR_FLOOR    = 256;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int SETTLE       = 8;

   typedef struct {
      req_type beat;
      bit      typed;
      rsp_type outcome;
   } opening_row_type;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;

   logic [15:0] queued_delay[$];
   logic [7:0]  queued_tag[$];
   logic        timer_running;
   logic [15:0] timer_left;
   logic [7:0]  timer_tag;

   rsp_type         alarms_due[$];
   opening_row_type opening[$];
   int              mismatch_count = 0;
   int              cycle_count = 0;

   sorted_alarm_queue_core DUT (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic rsp_type advance_alarms(input req_type beat);
      rsp_type outcome;
      int      slot;
      outcome = '0;
      if (beat.opcode == OP_INSERT) begin
         if (queued_delay.size() >= SAQ_DEPTH) begin
            outcome.rejected = 1'b1;
         end else begin
            slot = 0;
            while (slot < queued_delay.size() && queued_delay[slot] <= beat.delay_seconds)
               slot++;
            queued_delay.insert(slot, beat.delay_seconds);
            queued_tag.insert(slot, beat.alarm_id);
         end
      end else if (timer_running) begin
         if (timer_left <= 16'd1) begin
            outcome.fired     = 1'b1;
            outcome.fired_tag = timer_tag;
            timer_running     = 1'b0;
            timer_left        = '0;
         end else begin
            timer_left = timer_left - 16'd1;
         end
      end
      if (!timer_running && queued_delay.size() > 0) begin
         timer_left    = queued_delay.pop_front();
         timer_tag     = queued_tag.pop_front();
         timer_running = 1'b1;
      end
      outcome.pending = 5'(queued_delay.size());
      return outcome;
   endfunction

   function automatic bit tick_loads_far();
      return timer_running && timer_left <= 16'd1 && queued_delay.size() > 0
         && queued_delay[0] > SHORT_REACH;
   endfunction

   function automatic int far_entries();
      int total;
      total = 0;
      foreach (queued_delay[k])
         if (queued_delay[k] > SHORT_REACH) total++;
      return total;
   endfunction

   function automatic opening_row_type row_of(input op_type op, input int delay,
                                              input int tag, input bit typed,
                                              input bit fired, input int ftag,
                                              input bit rej, input int pend);
      opening_row_type row;
      row.beat.opcode        = op;
      row.beat.delay_seconds = 16'(delay);
      row.beat.alarm_id      = 8'(tag);
      row.typed              = typed;
      row.outcome.fired      = fired;
      row.outcome.fired_tag  = 8'(ftag);
      row.outcome.rejected   = rej;
      row.outcome.pending    = 5'(pend);
      return row;
   endfunction

   task automatic issue_beat(input req_type beat, input bit typed, input rsp_type typed_rsp,
                             input bit may_idle);
      rsp_type predicted;
      if (may_idle && $urandom_range(99) < 25) begin
         start <= 1'b0;
         repeat ($urandom_range(6, 1)) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= beat;
      do @(posedge clock); while (busy);
      predicted = advance_alarms(beat);
      alarms_due.push_back(typed ? typed_rsp : predicted);
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[sorted_alarm_queue_core] ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_type due;
      if (!reset && rsp_valid) begin
         if (alarms_due.size() == 0) begin
            $error("unexpected result beat %p", rsp_data);
            mismatch_count++;
         end else begin
            due = alarms_due.pop_front();
            if (rsp_data.fired !== due.fired) begin
               $error("fired: expected %0d, got %0d", due.fired, rsp_data.fired);
               mismatch_count++;
            end
            if (rsp_data.fired_tag !== due.fired_tag) begin
               $error("fired_tag: expected %0d, got %0d", due.fired_tag, rsp_data.fired_tag);
               mismatch_count++;
            end
            if (rsp_data.rejected !== due.rejected) begin
               $error("rejected: expected %0d, got %0d", due.rejected, rsp_data.rejected);
               mismatch_count++;
            end
            if (rsp_data.pending !== due.pending) begin
               $error("pending: expected %0d, got %0d", due.pending, rsp_data.pending);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      req_type beat;
      int      insert_pct;
      int      roll;
      int      fill_delay[14];
      timer_running  = 1'b0;
      timer_left     = '0;
      timer_tag      = '0;
      insert_pct     = 50;
      reset    <= 1'b1;
      start    <= 1'b0;
      req_data <= '0;

      opening.push_back(row_of(OP_TICK,   0,      8'h00, 1, 0, 8'h00, 0, 0));
      opening.push_back(row_of(OP_INSERT, 0,      8'hFF, 1, 0, 8'h00, 0, 0));
      opening.push_back(row_of(OP_TICK,   0,      8'h00, 1, 1, 8'hFF, 0, 0));
      opening.push_back(row_of(OP_INSERT, 1,      8'h01, 1, 0, 8'h00, 0, 0));
      opening.push_back(row_of(OP_INSERT, 16'hFFFF, 8'h00, 1, 0, 8'h00, 0, 1));
      opening.push_back(row_of(OP_INSERT, 3,      8'h02, 1, 0, 8'h00, 0, 2));
      opening.push_back(row_of(OP_INSERT, 3,      8'h03, 1, 0, 8'h00, 0, 3));
      opening.push_back(row_of(OP_INSERT, 1,      8'h04, 1, 0, 8'h00, 0, 4));
      opening.push_back(row_of(OP_TICK,   0,      8'h00, 1, 1, 8'h01, 0, 3));
      opening.push_back(row_of(OP_TICK,   0,      8'h00, 1, 1, 8'h04, 0, 2));
      fill_delay = '{4, 0, 6, 2, 3, 5, 1, 7, 2, 0, 4, 6, 3, 1};
      foreach (fill_delay[k])
         opening.push_back(row_of(OP_INSERT, fill_delay[k], 8'h10 + k, 0, 0, 0, 0, 0));
      opening.push_back(row_of(OP_INSERT, 2,      8'hA5, 1, 0, 8'h00, 1, 16));

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (opening[k])
         issue_beat(opening[k].beat, opening[k].typed, opening[k].outcome, 1'b1);

      for (int n = 0; n < RANDOM_BEATS; n++) begin
         if (n % 100 == 0) begin
            case ($urandom_range(2))
               0:       insert_pct = 30;
               1:       insert_pct = 50;
               default: insert_pct = 70;
            endcase
         end
         beat.delay_seconds = 16'($urandom);
         beat.alarm_id      = 8'($urandom);
         if (tick_loads_far()) begin
            beat.opcode        = OP_INSERT;
            beat.delay_seconds = 16'($urandom_range(7, 0));
         end else if ($urandom_range(99) < insert_pct) begin
            beat.opcode = OP_INSERT;
            roll        = $urandom_range(99);
            if (roll < 2 && far_entries() < 3)
               beat.delay_seconds = 16'($urandom_range(65535, FAR_FLOOR));
            else if (roll < 12)
               beat.delay_seconds = 16'($urandom_range(SHORT_REACH, 0));
            else
               beat.delay_seconds = 16'($urandom_range(7, 0));
         end else begin
            beat.opcode = OP_TICK;
         end
         issue_beat(beat, 1'b0, '0, !(n >= 400 && n < 700));
      end

      start <= 1'b0;
      while (alarms_due.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (mismatch_count == 0)
         $display("[sorted_alarm_queue_core] OK");
      else
         $display("[sorted_alarm_queue_core] ERROR");
      $finish;
   end

endmodule
